FILE: src/dsds_pkg.sv
// Package for the dust sensor display smoother: register indexes, reset
// values, scaling constants, level codes and the small modulo helpers.
// No dependencies.
package dsds_pkg;

   // Default block length of the sample accumulator
   localparam int SAMPLES_DEFAULT = 16;

   localparam int ADC_W     = 12;
   localparam int RND_W     = 15;
   localparam int VALUE_W   = 10;
   localparam int LEVEL_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = 16;
   localparam int TICK_W    = 16;
   localparam int CONF_W    = 8;
   localparam int OFFSET_W  = 16;

   // mean * 50000 / 4096 gives tenth-millivolts
   localparam logic [15:0] MV_SCALE       = 16'd50000;
   localparam int          MV_SHIFT       = 12;
   localparam int          MV_PROD_W      = ADC_W + 16;
   localparam int          TENTH_W        = 16;
   // x / 56 = (x >> 3) / 7; (y * 9363) >> 16 is exact for y < 8192
   localparam int          EST_PRE_SHIFT  = 3;
   localparam int          EST_Y_W        = TENTH_W - EST_PRE_SHIFT;
   localparam logic [13:0] EST_RECIP      = 14'd9363;
   localparam int          EST_RECIP_SH   = 16;
   localparam int          EST_PROD_W     = EST_Y_W + 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_MV        = 3'd0,
      CSR_JUMP_MARGIN      = 3'd1,
      CSR_CONFIRM_COUNT    = 3'd2,
      CSR_UPDATE_PERIOD    = 3'd3,
      CSR_LEVEL_GOOD_MAX   = 3'd4,
      CSR_LEVEL_FAIR_MAX   = 3'd5,
      CSR_LEVEL_MEDIUM_MAX = 3'd6,
      CSR_DISPLAY_MAX      = 3'd7
   } csr_index_type;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_EXCELLENT = 2'd0,
      LEVEL_GOOD      = 2'd1,
      LEVEL_MEDIUM    = 2'd2,
      LEVEL_BAD       = 2'd3
   } air_level_type;

   localparam logic [OFFSET_W-1:0] OFFSET_MV_RST        = 16'd3800;
   localparam logic [VALUE_W-1:0]  JUMP_MARGIN_RST      = 10'd20;
   localparam logic [CONF_W-1:0]   CONFIRM_COUNT_RST    = 8'd5;
   localparam logic [TICK_W-1:0]   UPDATE_PERIOD_RST    = 16'd200;
   localparam logic [VALUE_W-1:0]  LEVEL_GOOD_MAX_RST   = 10'd100;
   localparam logic [VALUE_W-1:0]  LEVEL_FAIR_MAX_RST   = 10'd200;
   localparam logic [VALUE_W-1:0]  LEVEL_MEDIUM_MAX_RST = 10'd300;
   localparam logic [VALUE_W-1:0]  DISPLAY_MAX_RST      = 10'd999;
   localparam logic [VALUE_W-1:0]  SHOWN_RST            = 10'd2;

   // x % 5 by nibble folding (16 = 1 mod 5)
   function automatic logic [2:0] mod5(input logic [RND_W-1:0] x);
      logic [5:0] s1;
      logic [4:0] s2;
      logic [4:0] s3;
      logic [4:0] s4;
      logic [4:0] s5;
      s1 = {2'b00, x[3:0]} + {2'b00, x[7:4]} + {2'b00, x[11:8]} + {3'b000, x[14:12]};
      s2 = {3'b000, s1[5:4]} + {1'b0, s1[3:0]};
      s3 = (s2 >= 5'd15) ? s2 - 5'd15 : s2;
      s4 = (s3 >= 5'd10) ? s3 - 5'd10 : s3;
      s5 = (s4 >= 5'd5) ? s4 - 5'd5 : s4;
      return s5[2:0];
   endfunction

   // x % 10 from x % 5 and the parity of x
   function automatic logic [3:0] mod10(input logic [RND_W-1:0] x);
      logic [2:0] r5;
      r5 = mod5(x);
      return (r5[0] == x[0]) ? {1'b0, r5} : {1'b0, r5} + 4'd5;
   endfunction

endpackage

FILE: src/dust_sensor_display_smoother.sv
// Dust sensor display smoother: sample accumulator, PM2.5 estimate pipeline
// and display update logic. Depends on dsds_pkg.
//
// Usage
//   One transfer on the req_ channel is one 1 ms tick. It carries a flag that
//   a fresh ADC sample is present, the sample, and a random word. Every tick
//   produces exactly one transfer on the rsp_ channel: the shown PM2.5 value,
//   its air level and a flag telling whether this tick updated the display.
//   Both channels use valid/stall; a transfer happens on a clock edge with
//   valid high and stall low.
//   csr_ writes take effect at the edge where csr_wr_en is high. Write only
//   while no tick is in flight.
// Timing
//   After the stage 1 register, the estimate path takes four register
//   stages: divide by SAMPLES (reciprocal multiply), scale to tenth-mV
//   (one multiply), offset subtract, divide by 56 (reciprocal multiply);
//   the display update and level compare sit in the output register's
//   stage. Throughput is one tick per cycle while rsp_stall is low.
// Reset and stall
//   Synchronous reset clears the pipeline, the accumulator, the tick counter
//   and the confirm counter, sets the shown value to 2 at excellent level
//   and loads the register defaults. While rsp_stall is high the output
//   holds; bubbles in the pipeline keep filling, and req_stall rises only
//   once all six stages hold a tick.
module dust_sensor_display_smoother #(
   parameter int SAMPLES = dsds_pkg::SAMPLES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // tick input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_sample_valid,
   input  logic [dsds_pkg::ADC_W-1:0]      req_adc_sample,
   input  logic [dsds_pkg::RND_W-1:0]      req_random_word,
   // display result
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dsds_pkg::VALUE_W-1:0]    rsp_shown_value,
   output logic [dsds_pkg::LEVEL_W-1:0]    rsp_air_level,
   output logic                            rsp_updated,
   // register writes
   input  logic                            csr_wr_en,
   input  logic [dsds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dsds_pkg::CSR_DW-1:0]     csr_wdata
);

   // accumulator widths follow from the block length
   localparam int SumW     = $clog2(SAMPLES * 4095 + 1);
   localparam int CntW     = $clog2(SAMPLES + 1);
   // floor(sum / SAMPLES) = (sum * DivMult) >> DivShift, exact for sum < 2**SumW
   localparam int DivShift = SumW + $clog2(SAMPLES);
   localparam int DivMultW = DivShift + 1;
   localparam logic [DivMultW-1:0] DivMult =
      DivMultW'(((1 << DivShift) + SAMPLES - 1) / SAMPLES);
   localparam int DivProdW = SumW + DivMultW;
   localparam int NStages  = 5;

   localparam int VW = dsds_pkg::VALUE_W;
   localparam int CW = dsds_pkg::CONF_W;

   // ---------------- configuration registers ----------------
   logic [dsds_pkg::OFFSET_W-1:0] offset_mv_ff;
   logic [VW-1:0]                 jump_margin_ff;
   logic [CW-1:0]                 confirm_count_ff;
   logic [dsds_pkg::TICK_W-1:0]   update_period_ff;
   logic [VW-1:0]                 level_good_max_ff;
   logic [VW-1:0]                 level_fair_max_ff;
   logic [VW-1:0]                 level_medium_max_ff;
   logic [VW-1:0]                 display_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_mv_ff        <= dsds_pkg::OFFSET_MV_RST;
         jump_margin_ff      <= dsds_pkg::JUMP_MARGIN_RST;
         confirm_count_ff    <= dsds_pkg::CONFIRM_COUNT_RST;
         update_period_ff    <= dsds_pkg::UPDATE_PERIOD_RST;
         level_good_max_ff   <= dsds_pkg::LEVEL_GOOD_MAX_RST;
         level_fair_max_ff   <= dsds_pkg::LEVEL_FAIR_MAX_RST;
         level_medium_max_ff <= dsds_pkg::LEVEL_MEDIUM_MAX_RST;
         display_max_ff      <= dsds_pkg::DISPLAY_MAX_RST;
      end else if (csr_wr_en) begin
         unique case (dsds_pkg::csr_index_type'(csr_index))
            dsds_pkg::CSR_OFFSET_MV:        offset_mv_ff        <= csr_wdata;
            dsds_pkg::CSR_JUMP_MARGIN:      jump_margin_ff      <= csr_wdata[VW-1:0];
            dsds_pkg::CSR_CONFIRM_COUNT:    confirm_count_ff    <= csr_wdata[CW-1:0];
            dsds_pkg::CSR_UPDATE_PERIOD:    update_period_ff    <= csr_wdata;
            dsds_pkg::CSR_LEVEL_GOOD_MAX:   level_good_max_ff   <= csr_wdata[VW-1:0];
            dsds_pkg::CSR_LEVEL_FAIR_MAX:   level_fair_max_ff   <= csr_wdata[VW-1:0];
            dsds_pkg::CSR_LEVEL_MEDIUM_MAX: level_medium_max_ff <= csr_wdata[VW-1:0];
            dsds_pkg::CSR_DISPLAY_MAX:      display_max_ff      <= csr_wdata[VW-1:0];
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   // stage k may load when it is empty or its content moves on
   logic [NStages:1] st_v_ff;
   logic [NStages:1] st_rdy;
   logic             out_rdy;
   logic             req_xfer;
   logic             out_load;

   always_comb begin
      out_rdy          = !rsp_valid || !rsp_stall;
      st_rdy[NStages]  = !st_v_ff[NStages] || out_rdy;
      for (int k = NStages - 1; k >= 1; k--) begin
         st_rdy[k] = !st_v_ff[k] || st_rdy[k+1];
      end
   end

   assign req_stall = !st_rdy[1];
   assign req_xfer  = req_valid && st_rdy[1];
   assign out_load  = st_v_ff[NStages] && out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff <= '0;
      end else begin
         if (st_rdy[1]) begin
            st_v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NStages; k++) begin
            if (st_rdy[k]) begin
               st_v_ff[k] <= st_v_ff[k-1];
            end
         end
      end
   end

   // ---------------- accept: accumulator and tick counter ----------------
   logic [SumW-1:0]               sum_ff;
   logic [SumW-1:0]               sum_in;
   logic [CntW-1:0]               count_ff;
   logic [CntW-1:0]               count_in;
   logic                          block_done;
   logic [dsds_pkg::TICK_W-1:0]   tick_ff;
   logic [dsds_pkg::TICK_W-1:0]   tick_in;
   logic                          tick_upd;

   always_comb begin
      sum_in     = sum_ff + SumW'(req_adc_sample);
      count_in   = count_ff + CntW'(1);
      block_done = req_sample_valid && (count_in == CntW'(SAMPLES));
      tick_in    = tick_ff + dsds_pkg::TICK_W'(1);
      tick_upd   = tick_in > update_period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         tick_ff  <= '0;
      end else if (req_xfer) begin
         if (req_sample_valid) begin
            sum_ff   <= block_done ? '0 : sum_in;
            count_ff <= block_done ? '0 : count_in;
         end
         tick_ff <= tick_upd ? '0 : tick_in;
      end
   end

   // ---------------- stage 1: block sum, random word ----------------
   logic [SumW-1:0]               st1_sum_ff;
   logic                          st1_done_ff;
   logic                          st1_upd_ff;
   logic [dsds_pkg::RND_W-1:0]    st1_rnd_ff;

   always_ff @(posedge clock) begin
      if (st_rdy[1]) begin
         st1_sum_ff  <= sum_in;
         st1_done_ff <= block_done;
         st1_upd_ff  <= tick_upd;
         st1_rnd_ff  <= req_random_word;
      end
   end

   // ---------------- stage 2: sum * reciprocal, random residues ----------------
   logic [DivProdW-1:0]           st2_prod_ff;
   logic                          st2_done_ff;
   logic                          st2_upd_ff;
   logic [3:0]                    st2_r10_ff;
   logic [2:0]                    st2_r5_ff;

   always_ff @(posedge clock) begin
      if (st_rdy[2]) begin
         st2_prod_ff <= DivProdW'(st1_sum_ff) * DivProdW'(DivMult);
         st2_done_ff <= st1_done_ff;
         st2_upd_ff  <= st1_upd_ff;
         st2_r10_ff  <= dsds_pkg::mod10(st1_rnd_ff);
         st2_r5_ff   <= dsds_pkg::mod5(st1_rnd_ff);
      end
   end

   // ---------------- stage 3: mean * 50000 ----------------
   logic [dsds_pkg::ADC_W-1:0]     st2_mean;
   logic [dsds_pkg::MV_PROD_W-1:0] st3_prod_ff;
   logic                           st3_done_ff;
   logic                           st3_upd_ff;
   logic [3:0]                     st3_r10_ff;
   logic [2:0]                     st3_r5_ff;

   assign st2_mean = st2_prod_ff[DivShift +: dsds_pkg::ADC_W];

   always_ff @(posedge clock) begin
      if (st_rdy[3]) begin
         st3_prod_ff <= dsds_pkg::MV_PROD_W'(st2_mean) *
                        dsds_pkg::MV_PROD_W'(dsds_pkg::MV_SCALE);
         st3_done_ff <= st2_done_ff;
         st3_upd_ff  <= st2_upd_ff;
         st3_r10_ff  <= st2_r10_ff;
         st3_r5_ff   <= st2_r5_ff;
      end
   end

   // ---------------- stage 4: tenth-mV minus offset, floored ----------------
   logic [dsds_pkg::TENTH_W-1:0]  st3_tenth;
   logic [dsds_pkg::TENTH_W-1:0]  st3_net;
   logic [dsds_pkg::EST_Y_W-1:0]  st4_y_ff;
   logic                          st4_done_ff;
   logic                          st4_upd_ff;
   logic [3:0]                    st4_r10_ff;
   logic [2:0]                    st4_r5_ff;

   always_comb begin
      st3_tenth = st3_prod_ff[dsds_pkg::MV_SHIFT +: dsds_pkg::TENTH_W];
      st3_net   = (st3_tenth > offset_mv_ff) ? st3_tenth - offset_mv_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (st_rdy[4]) begin
         st4_y_ff    <= st3_net[dsds_pkg::TENTH_W-1:dsds_pkg::EST_PRE_SHIFT];
         st4_done_ff <= st3_done_ff;
         st4_upd_ff  <= st3_upd_ff;
         st4_r10_ff  <= st3_r10_ff;
         st4_r5_ff   <= st3_r5_ff;
      end
   end

   // ---------------- stage 5: divide by 7 via reciprocal ----------------
   logic [dsds_pkg::EST_PROD_W-1:0] st5_prod_ff;
   logic                            st5_done_ff;
   logic                            st5_upd_ff;
   logic [3:0]                      st5_r10_ff;
   logic [2:0]                      st5_r5_ff;

   always_ff @(posedge clock) begin
      if (st_rdy[5]) begin
         st5_prod_ff <= dsds_pkg::EST_PROD_W'(st4_y_ff) *
                        dsds_pkg::EST_PROD_W'(dsds_pkg::EST_RECIP);
         st5_done_ff <= st4_done_ff;
         st5_upd_ff  <= st4_upd_ff;
         st5_r10_ff  <= st4_r10_ff;
         st5_r5_ff   <= st4_r5_ff;
      end
   end

   // ---------------- output stage: display update ----------------
   // The shown value, level and confirm counter are the block's display
   // state; the shown value and level double as the output register.
   logic [VW-1:0]                 est_ff;
   logic [VW-1:0]                 est_in;
   logic [VW-1:0]                 shown_ff;
   logic [VW-1:0]                 shown_in;
   dsds_pkg::air_level_type       level_ff;
   dsds_pkg::air_level_type       level_in;
   logic [CW-1:0]                 conf_ff;
   logic [CW-1:0]                 conf_in;
   logic                          rsp_valid_ff;
   logic                          updated_ff;

   logic [VW-1:0]                 s_step;
   logic [CW-1:0]                 conf_inc;
   logic                          big_drop;

   always_comb begin
      est_in   = st5_done_ff ? st5_prod_ff[dsds_pkg::EST_RECIP_SH +: VW] : est_ff;
      shown_in = shown_ff;
      level_in = level_ff;
      conf_in  = conf_ff;
      s_step   = shown_ff;
      conf_inc = (conf_ff != '1) ? conf_ff + CW'(1) : conf_ff;
      big_drop = ({1'b0, est_in} + {1'b0, jump_margin_ff}) < {1'b0, shown_ff};

      if (st5_upd_ff) begin
         if (big_drop) begin
            // step down by a random 0..9, floored at zero
            s_step = (shown_ff > VW'(st5_r10_ff)) ? shown_ff - VW'(st5_r10_ff) : '0;
         end else if (est_in > shown_ff) begin
            // only a large rise is taken at once
            if ((est_in - shown_ff) > jump_margin_ff) begin
               s_step = est_in;
            end
         end else begin
            // small drop or equal: adopt after enough confirming updates
            conf_in = conf_inc;
            if (conf_inc >= confirm_count_ff) begin
               conf_in = '0;
               s_step  = (est_in == '0) ? VW'(st5_r5_ff) + VW'(1) : est_in;
            end
         end

         shown_in = (s_step >= display_max_ff) ? display_max_ff : s_step;

         if (shown_in <= level_good_max_ff) begin
            level_in = dsds_pkg::LEVEL_EXCELLENT;
         end else if (shown_in <= level_fair_max_ff) begin
            level_in = dsds_pkg::LEVEL_GOOD;
         end else if (shown_in <= level_medium_max_ff) begin
            level_in = dsds_pkg::LEVEL_MEDIUM;
         end else begin
            level_in = dsds_pkg::LEVEL_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         est_ff       <= '0;
         shown_ff     <= dsds_pkg::SHOWN_RST;
         level_ff     <= dsds_pkg::LEVEL_EXCELLENT;
         conf_ff      <= '0;
         updated_ff   <= 1'b0;
      end else begin
         if (out_rdy) begin
            rsp_valid_ff <= st_v_ff[NStages];
         end
         if (out_load) begin
            est_ff     <= est_in;
            shown_ff   <= shown_in;
            level_ff   <= level_in;
            conf_ff    <= conf_in;
            updated_ff <= st5_upd_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shown_value = shown_ff;
   assign rsp_air_level   = level_ff;
   assign rsp_updated     = updated_ff;

   // ---------------- assertions ----------------
   // a tick without an update leaves the shown value alone
   a_no_update_hold: assert property (@(posedge clock) disable iff (reset)
      (out_load && !st5_upd_ff) |=> $stable(shown_ff))
      else $error("shown value moved on a tick without update");

   // the sample counter wraps before it reaches the block length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CntW'(SAMPLES))
      else $error("sample counter reached block length");

   // an updating tick restarts the tick counter
   a_tick_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && tick_upd) |=> (tick_ff == '0))
      else $error("tick counter not restarted after update");

   // input is held off only with every stage and the output full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&st_v_ff) && rsp_valid && rsp_stall))
      else $error("input stalled with a free pipeline stage");

endmodule

FILE: verif/tb_dust_sensor_display_smoother.sv
`timescale 1ns / 1ps
// Self-checking testbench for dust_sensor_display_smoother: a directed table, then random
// register phases with random ticks. Results are checked against an in-bench smoother or
// against a row's hand-written expectation. Depends on dsds_pkg and the smoother RTL.
module tb_dust_sensor_display_smoother;

   localparam int BLOCK_LEN    = dsds_pkg::SAMPLES_DEFAULT;
   localparam int ITEM_TARGET  = 600;
   localparam int DRAIN_CYCLES = 12;      // comfortably above the pipeline latency
   localparam int CYCLE_LIMIT  = 250000;

   localparam int VW = dsds_pkg::VALUE_W;
   localparam int DW = dsds_pkg::CSR_DW;
   localparam int AW = dsds_pkg::ADC_W;
   localparam int RW = dsds_pkg::RND_W;

   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   // one display result as the rsp_ channel carries it
   typedef struct {
      logic [VW-1:0]           shown;
      dsds_pkg::air_level_type level;
      logic                    updated;
   } display_type;

   // one stimulus row: either a tick or a register write
   typedef struct {
      row_kind_type            kind;
      dsds_pkg::csr_index_type reg_idx;
      logic [DW-1:0]           reg_data;
      logic                    sample_valid;
      logic [AW-1:0]           adc;
      logic [RW-1:0]           rnd;
      bit                      typed;     // want holds a hand-written expectation
      display_type             want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_sample_valid;
   logic [AW-1:0]                  req_adc_sample;
   logic [RW-1:0]                  req_random_word;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [VW-1:0]                  rsp_shown_value;
   logic [dsds_pkg::LEVEL_W-1:0]   rsp_air_level;
   logic                           rsp_updated;
   logic                           csr_wr_en;
   logic [dsds_pkg::CSR_IDX_W-1:0] csr_index;
   logic [DW-1:0]                  csr_wdata;

   // expected display results, oldest first
   display_type pending_display[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  tx_idle_on     = 1'b1;
   bit  rx_idle_on     = 1'b1;
   int  long_hold      = 0;   // receiver hold-off request, in cycles

   // smoother state as seen by the bench
   logic [17:0]                    acc_sum;
   logic [6:0]                     acc_count;
   logic [VW-1:0]                  est_value;
   logic [VW-1:0]                  shown_m;
   logic [dsds_pkg::CONF_W-1:0]    confirm_cnt;
   logic [dsds_pkg::TICK_W-1:0]    tick_cnt;
   dsds_pkg::air_level_type        level_m;

   // register copies
   logic [dsds_pkg::OFFSET_W-1:0]  offset_tmv;
   logic [VW-1:0]                  margin;
   logic [dsds_pkg::CONF_W-1:0]    confirm_need;
   logic [dsds_pkg::TICK_W-1:0]    period;
   logic [VW-1:0]                  good_max;
   logic [VW-1:0]                  fair_max;
   logic [VW-1:0]                  medium_max;
   logic [VW-1:0]                  disp_max;

   dust_sensor_display_smoother #(
      .SAMPLES(BLOCK_LEN)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_valid(req_sample_valid),
      .req_adc_sample  (req_adc_sample),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shown_value (rsp_shown_value),
      .rsp_air_level   (rsp_air_level),
      .rsp_updated     (rsp_updated),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Advance the smoother by one tick and return the display it shows afterwards.
   // The sample is folded in (closing a block if full) before the tick counter moves.
   function automatic display_type next_display(input stim_row_type row);
      int unsigned mean;
      int unsigned tenth;
      int unsigned e;
      int unsigned s;
      int unsigned d;
      display_type res;
      res.updated = 1'b0;
      if (row.sample_valid) begin
         acc_sum   = acc_sum + 18'(row.adc);
         acc_count = acc_count + 7'd1;
         if (acc_count >= BLOCK_LEN) begin
            mean      = acc_sum / BLOCK_LEN;
            tenth     = mean * 50000 / 4096;
            tenth     = (tenth > offset_tmv) ? tenth - offset_tmv : 0;
            est_value = VW'(tenth / 56);
            acc_sum   = '0;
            acc_count = '0;
         end
      end
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt > period) begin
         tick_cnt    = '0;
         res.updated = 1'b1;
         e = est_value;
         s = shown_m;
         if (e + margin < s) begin
            // large drop: step down, floored at zero
            d = row.rnd % 10;
            s = (s > d) ? s - d : 0;
         end else if (e > s) begin
            if (e - s > margin)
               s = e;
         end else begin
            // small or no change needs confirming; counter sticks at its top
            if (confirm_cnt != 8'd255)
               confirm_cnt = confirm_cnt + 8'd1;
            if (confirm_cnt >= confirm_need) begin
               confirm_cnt = '0;
               s = e;
               if (s == 0)
                  s = row.rnd % 5 + 1;
            end
         end
         if (s >= disp_max)
            s = disp_max;
         shown_m = VW'(s);
         // limits are tested in order, even when they are not ascending
         if (shown_m <= good_max)
            level_m = dsds_pkg::LEVEL_EXCELLENT;
         else if (shown_m <= fair_max)
            level_m = dsds_pkg::LEVEL_GOOD;
         else if (shown_m <= medium_max)
            level_m = dsds_pkg::LEVEL_MEDIUM;
         else
            level_m = dsds_pkg::LEVEL_BAD;
      end
      res.shown = shown_m;
      res.level = level_m;
      return res;
   endfunction

   function automatic stim_row_type tick_row(input logic sv, input logic [AW-1:0] adc,
                                             input logic [RW-1:0] rnd);
      stim_row_type row;
      row.kind         = ROW_TICK;
      row.reg_idx      = dsds_pkg::CSR_OFFSET_MV;
      row.reg_data     = '0;
      row.sample_valid = sv;
      row.adc          = adc;
      row.rnd          = rnd;
      row.typed        = 1'b0;
      row.want.shown   = '0;
      row.want.level   = dsds_pkg::LEVEL_EXCELLENT;
      row.want.updated = 1'b0;
      return row;
   endfunction

   function automatic stim_row_type typed_tick(input logic sv, input logic [AW-1:0] adc,
                                               input logic [RW-1:0] rnd,
                                               input logic [VW-1:0] shown,
                                               input dsds_pkg::air_level_type level,
                                               input logic upd);
      stim_row_type row;
      row              = tick_row(sv, adc, rnd);
      row.typed        = 1'b1;
      row.want.shown   = shown;
      row.want.level   = level;
      row.want.updated = upd;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input dsds_pkg::csr_index_type idx,
                                            input logic [DW-1:0] data);
      stim_row_type row;
      row          = tick_row(1'b0, '0, '0);
      row.kind     = ROW_CSR;
      row.reg_idx  = idx;
      row.reg_data = data;
      return row;
   endfunction

   // random per-transfer wait, or none during a no-idle stretch
   function automatic int draw_wait(input bit enabled);
      return enabled ? int'($urandom_range(0, 8)) : 0;
   endfunction

   // random junk above a narrow register's width; the block must drop it
   function automatic logic [DW-1:0] pad_high(input logic [DW-1:0] v, input int w);
      logic [DW-1:0] junk;
      junk = DW'($urandom) << w;
      return ($urandom_range(0, 1) != 0) ? (v | junk) : v;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Register write: only with the pipe drained and after a further drain margin.
   task automatic write_register(input dsds_pkg::csr_index_type idx,
                                 input logic [DW-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_display.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         dsds_pkg::CSR_OFFSET_MV:        offset_tmv   = data;
         dsds_pkg::CSR_JUMP_MARGIN:      margin       = data[VW-1:0];
         dsds_pkg::CSR_CONFIRM_COUNT:    confirm_need = data[dsds_pkg::CONF_W-1:0];
         dsds_pkg::CSR_UPDATE_PERIOD:    period       = data;
         dsds_pkg::CSR_LEVEL_GOOD_MAX:   good_max     = data[VW-1:0];
         dsds_pkg::CSR_LEVEL_FAIR_MAX:   fair_max     = data[VW-1:0];
         dsds_pkg::CSR_LEVEL_MEDIUM_MAX: medium_max   = data[VW-1:0];
         dsds_pkg::CSR_DISPLAY_MAX:      disp_max     = data[VW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One req_ transfer. Valid stays high across back-to-back ticks; the expectation
   // is worked out at the accepting edge.
   task automatic send_tick(input stim_row_type row);
      int          gap;
      display_type want;
      gap = draw_wait(tx_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_valid <= row.sample_valid;
      req_adc_sample   <= row.adc;
      req_random_word  <= row.rnd;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = next_display(row);
      if (row.typed)
         want = row.want;
      pending_display.push_back(want);
   endtask

   // rsp_ side: random hold-offs (or a long one on request), then take one transfer
   // and compare it with the oldest expectation.
   initial begin : result_checker
      int          hold;
      display_type want;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            hold      = long_hold;
            long_hold = 0;
         end else begin
            hold = draw_wait(rx_idle_on);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_display.size() == 0) begin
            note_mismatch("result transfer with no tick outstanding");
         end else begin
            want = pending_display.pop_front();
            if (rsp_shown_value !== want.shown)
               note_mismatch($sformatf("shown_value %0d, expected %0d",
                                       rsp_shown_value, want.shown));
            if (rsp_air_level !== want.level)
               note_mismatch($sformatf("air_level %0d, expected %0d",
                                       rsp_air_level, want.level));
            if (rsp_updated !== want.updated)
               note_mismatch($sformatf("updated %0b, expected %0b",
                                       rsp_updated, want.updated));
         end
      end
   end

   initial begin : stimulus
      stim_row_type      rows[$];
      stim_row_type      row;
      int                random_items;
      int                phase;
      int                n;
      int                base;
      int                a;
      int                g;
      int                f;
      int                m;
      bit                noisy;
      logic [DW-1:0]     v;

      // every input known from time zero
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_valid = 1'b0;
      req_adc_sample   = '0;
      req_random_word  = '0;
      rsp_stall        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = dsds_pkg::CSR_OFFSET_MV;
      csr_wdata        = '0;

      // state and registers after reset
      acc_sum      = '0;
      acc_count    = '0;
      est_value    = '0;
      shown_m      = dsds_pkg::SHOWN_RST;
      confirm_cnt  = '0;
      tick_cnt     = '0;
      level_m      = dsds_pkg::LEVEL_EXCELLENT;
      offset_tmv   = dsds_pkg::OFFSET_MV_RST;
      margin       = dsds_pkg::JUMP_MARGIN_RST;
      confirm_need = dsds_pkg::CONFIRM_COUNT_RST;
      period       = dsds_pkg::UPDATE_PERIOD_RST;
      good_max     = dsds_pkg::LEVEL_GOOD_MAX_RST;
      fair_max     = dsds_pkg::LEVEL_FAIR_MAX_RST;
      medium_max   = dsds_pkg::LEVEL_MEDIUM_MAX_RST;
      disp_max     = dsds_pkg::DISPLAY_MAX_RST;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // ---- directed table ----
      // after reset: no update yet, shown 2 at excellent
      rows.push_back(typed_tick(1'b0, 12'd0, 15'd0, 10'd2, dsds_pkg::LEVEL_EXCELLENT, 1'b0));
      rows.push_back(typed_tick(1'b1, 12'hFFF, 15'h7FFF, 10'd2,
                                dsds_pkg::LEVEL_EXCELLENT, 1'b0));
      // update every tick, no offset, no margin, adopt on the first confirming update
      rows.push_back(csr_row(dsds_pkg::CSR_UPDATE_PERIOD, 16'd0));
      rows.push_back(csr_row(dsds_pkg::CSR_OFFSET_MV, 16'd0));
      rows.push_back(csr_row(dsds_pkg::CSR_JUMP_MARGIN, 16'd0));
      rows.push_back(csr_row(dsds_pkg::CSR_CONFIRM_COUNT, 16'd0));
      // estimate 0 below shown 2: step down by 9 floors at zero
      rows.push_back(typed_tick(1'b1, 12'hFFF, 15'd9, 10'd0, dsds_pkg::LEVEL_EXCELLENT, 1'b1));
      // equal at zero: adopted and replaced by rnd%5+1, then step-downs and confirms
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'h7FFF));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd0));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd5));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd12345));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'h7FFF));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd1));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd9));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd4));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'h3FFF));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'h4000));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd3));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'd7));
      rows.push_back(tick_row(1'b1, 12'hFFF, 15'h2AAA));
      // block of full-scale samples closes: estimate 892 jumps in, bad level
      rows.push_back(typed_tick(1'b1, 12'hFFF, 15'd0, 10'd892, dsds_pkg::LEVEL_BAD, 1'b1));
      // clamp to a display maximum of zero
      rows.push_back(csr_row(dsds_pkg::CSR_DISPLAY_MAX, 16'd0));
      rows.push_back(typed_tick(1'b0, 12'd0, 15'd0, 10'd0, dsds_pkg::LEVEL_EXCELLENT, 1'b1));
      // top clamp written with junk above bit 9; level limits out of order
      rows.push_back(csr_row(dsds_pkg::CSR_DISPLAY_MAX, 16'hFFFF));
      rows.push_back(csr_row(dsds_pkg::CSR_LEVEL_GOOD_MAX, 16'd10));
      rows.push_back(csr_row(dsds_pkg::CSR_LEVEL_FAIR_MAX, 16'd5));
      rows.push_back(csr_row(dsds_pkg::CSR_LEVEL_MEDIUM_MAX, 16'd1000));
      rows.push_back(typed_tick(1'b0, 12'd0, 15'd0, 10'd892, dsds_pkg::LEVEL_MEDIUM, 1'b1));
      // largest period: the counter can never pass it
      rows.push_back(csr_row(dsds_pkg::CSR_UPDATE_PERIOD, 16'hFFFF));
      rows.push_back(typed_tick(1'b0, 12'd0, 15'h7FFF, 10'd892, dsds_pkg::LEVEL_MEDIUM, 1'b0));
      rows.push_back(typed_tick(1'b1, 12'd0, 15'd0, 10'd892, dsds_pkg::LEVEL_MEDIUM, 1'b0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR)
            write_register(rows[i].reg_idx, rows[i].reg_data);
         else
            send_tick(rows[i]);
      end

      // ---- random phases: fresh registers, then a run of ticks ----
      random_items = 0;
      phase        = 0;
      base         = 2000;
      while (random_items < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            default: v = DW'($urandom_range(0, 30000));
         endcase
         write_register(dsds_pkg::CSR_OFFSET_MV, v);
         case ($urandom_range(0, 4))
            0:       v = 16'd0;
            1:       v = 16'd1023;
            default: v = DW'($urandom_range(0, 40));
         endcase
         write_register(dsds_pkg::CSR_JUMP_MARGIN, pad_high(v, VW));
         case ($urandom_range(0, 5))
            0:       v = 16'd0;
            1:       v = 16'd255;
            default: v = DW'($urandom_range(1, 8));
         endcase
         write_register(dsds_pkg::CSR_CONFIRM_COUNT, pad_high(v, dsds_pkg::CONF_W));
         case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = DW'($urandom_range(150, 260));
            default: v = DW'($urandom_range(1, 12));
         endcase
         write_register(dsds_pkg::CSR_UPDATE_PERIOD, v);
         if ($urandom_range(0, 3) == 0) begin
            // limits in any order
            g = $urandom_range(0, 1023);
            f = $urandom_range(0, 1023);
            m = $urandom_range(0, 1023);
         end else begin
            g = $urandom_range(0, 400);
            f = g + int'($urandom_range(0, 300));
            m = f + int'($urandom_range(0, 300));
         end
         write_register(dsds_pkg::CSR_LEVEL_GOOD_MAX, pad_high(DW'(g), VW));
         write_register(dsds_pkg::CSR_LEVEL_FAIR_MAX, pad_high(DW'(f), VW));
         write_register(dsds_pkg::CSR_LEVEL_MEDIUM_MAX, pad_high(DW'(m), VW));
         case ($urandom_range(0, 4))
            0:       v = DW'($urandom_range(0, 20));
            1:       v = 16'd1023;
            default: v = DW'($urandom_range(200, 1023));
         endcase
         write_register(dsds_pkg::CSR_DISPLAY_MAX, pad_high(v, VW));

         tx_idle_on = ($urandom_range(0, 2) != 0);
         rx_idle_on = ($urandom_range(0, 2) != 0);
         noisy      = ($urandom_range(0, 4) == 0);
         if (phase == 2 || phase == 9) begin
            // receiver sits still while ticks keep coming, so the pipe backs up
            tx_idle_on = 1'b0;
            long_hold  = 90;
         end
         n = (period == 16'hFFFF) ? 10 : int'($urandom_range(15, 45));

         repeat (n) begin
            if (noisy) begin
               row = tick_row(1'($urandom_range(0, 1)), AW'($urandom_range(0, 4095)),
                              RW'($urandom_range(0, 32767)));
            end else begin
               // new dust level at each block start: a fresh one or a drift
               if (acc_count == 0) begin
                  case ($urandom_range(0, 5))
                     0:       base = 0;
                     1:       base = 4095;
                     2, 3:    base = $urandom_range(0, 4095);
                     default: base = base + int'($urandom_range(0, 300)) - 150;
                  endcase
                  if (base < 0)
                     base = 0;
                  if (base > 4095)
                     base = 4095;
               end
               a = base + int'($urandom_range(0, 80)) - 40;
               if (a < 0)
                  a = 0;
               if (a > 4095)
                  a = 4095;
               row = tick_row($urandom_range(0, 9) != 0, AW'(a),
                              RW'($urandom_range(0, 32767)));
            end
            send_tick(row);
            random_items++;
         end
         phase++;
      end

      // let the last results come home
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_display.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
